// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the dump region file offset RTL.
// Takes a clock, an active-low reset and a property expression.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every clock edge outside reset.
`define DRFO_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Never let cond be true outside reset.
`define DRFO_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `DRFO_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/drfo_pkg.sv =====
// Package for the dump region file offset unit: widths, codes, table entry
// type and the saturating offset add. No dependencies.
`timescale 1ns / 1ps

package drfo_pkg;

  localparam int unsigned MaxBlocks = 32;
  localparam int unsigned AddrW     = 48;
  localparam int unsigned OffW      = AddrW + 1;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = 6;
  localparam int unsigned CfgIdxW   = 3;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [OffW-1:0]  off_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MEMORY_OFFSET = 3'd0,
    REG_FILTER_ENABLE = 3'd1,
    REG_FILTER_BEGIN  = 3'd2,
    REG_FILTER_LENGTH = 3'd3,
    REG_BLOCK_COUNT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    addr_t base;
    off_t  bend;
  } entry_t;

  function automatic off_t sat_add(off_t a, off_t b);
    logic [OffW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OffW] ? {OffW{1'b1}} : s[OffW-1:0];
  endfunction

endpackage

// ===== rtl/dump_region_file_offset_unit.sv =====
// Dump region file offset unit: block table memory, query walk pipeline,
// configuration registers and output register. Uses drfo_pkg, assert_macros.svh.
`timescale 1ns / 1ps

// A write word stores one table entry. A query word walks the first
// min(block_count, 32) entries from the table memory, one entry per cycle
// through a three-stage pipeline behind its read port, and stops at the first
// clipped block that holds the address. The walk is skipped when the address
// falls outside the filter window or the table is empty. Input is stalled
// while a query is in progress; a finished result waits in the output
// register while the next word is accepted.
`include "assert_macros.svh"

module dump_region_file_offset_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [drfo_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [drfo_pkg::AddrW-1:0]   cfg_data_i,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [drfo_pkg::IdxW-1:0]    entry_index_i,
  input  logic [drfo_pkg::AddrW-1:0]   entry_base_i,
  input  logic [drfo_pkg::AddrW-1:0]   entry_size_i,
  input  logic [drfo_pkg::AddrW-1:0]   phys_addr_i,
  input  logic [drfo_pkg::AddrW-1:0]   map_length_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [drfo_pkg::OffW-1:0]    file_offset_o,
  output logic [drfo_pkg::AddrW-1:0]   file_size_o
);

  drfo_pkg::state_e state_q, state_d;

  drfo_pkg::addr_t mem_offset_q, filt_begin_q, filt_length_q;
  logic            filt_en_q;
  drfo_pkg::cnt_t  block_count_q;

  drfo_pkg::entry_t table_mem [drfo_pkg::MaxBlocks];
  drfo_pkg::entry_t rd_q;

  drfo_pkg::addr_t phys_q, maplen_q;
  drfo_pkg::off_t  wend_q, pmend_q, run_q;
  drfo_pkg::cnt_t  n_q, iss_q;

  logic            v0_q, v1_q, v2_q;
  logic            l0_q, l1_q, l2_q;
  drfo_pkg::addr_t start1_q;
  drfo_pkg::off_t  stop1_q;
  logic            empty1_q;
  drfo_pkg::off_t  size2_q;
  drfo_pkg::addr_t into2_q, fsize2_q;
  logic            hit2_q;

  logic            res_found_q;
  drfo_pkg::off_t  res_off_q;
  drfo_pkg::addr_t res_size_q;

  logic            out_valid_q, out_found_q;
  drfo_pkg::off_t  out_off_q;
  drfo_pkg::addr_t out_size_q;

  logic            in_accept, wr_en, rd_en, out_load, filt_miss, walk_stay;
  drfo_pkg::addr_t start1_d;
  drfo_pkg::off_t  stop1_d, size2_d, rem2_d, run_sum, hit_off;
  logic            empty1_d, hit2_d;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign filt_miss   = filt_en_q && ((phys_q < filt_begin_q) || ({1'b0, phys_q} >= wend_q));
  assign walk_stay   = (state_d == drfo_pkg::ST_WALK);

  always_comb begin
    state_d = state_q;
    case (state_q)
      drfo_pkg::ST_IDLE: begin
        if (in_accept && command_i == drfo_pkg::CMD_QUERY) state_d = drfo_pkg::ST_PREP;
      end
      drfo_pkg::ST_PREP: state_d = drfo_pkg::ST_CHECK;
      drfo_pkg::ST_CHECK: begin
        if (filt_miss || n_q == '0) state_d = drfo_pkg::ST_DONE;
        else state_d = drfo_pkg::ST_WALK;
      end
      drfo_pkg::ST_WALK: begin
        if (v2_q && (hit2_q || l2_q)) state_d = drfo_pkg::ST_DONE;
      end
      drfo_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = drfo_pkg::ST_IDLE;
      end
      default: state_d = drfo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != drfo_pkg::ST_IDLE);
    rd_en      = (state_q == drfo_pkg::ST_WALK) && (iss_q < n_q);
    out_load   = (state_q == drfo_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
    wr_en      = in_valid_i && (state_q == drfo_pkg::ST_IDLE) &&
                 (command_i == drfo_pkg::CMD_WRITE) &&
                 ({1'b0, entry_index_i} < drfo_pkg::CntW'(drfo_pkg::MaxBlocks));
  end

  // clip stage
  always_comb begin
    if (filt_en_q) begin
      empty1_d = ({1'b0, rd_q.base} >= wend_q) || (rd_q.bend <= {1'b0, filt_begin_q});
      start1_d = (filt_begin_q <= rd_q.base) ? rd_q.base : filt_begin_q;
      stop1_d  = (wend_q < rd_q.bend) ? wend_q : rd_q.bend;
    end else begin
      empty1_d = 1'b0;
      start1_d = rd_q.base;
      stop1_d  = rd_q.bend;
    end
  end

  // match stage
  always_comb begin
    size2_d = empty1_q ? '0 : (stop1_q - {1'b0, start1_q});
    hit2_d  = !empty1_q && (phys_q >= start1_q) && ({1'b0, phys_q} < stop1_q);
    rem2_d  = stop1_q - {1'b0, phys_q};
  end

  // accumulate stage
  assign run_sum = drfo_pkg::sat_add(run_q, size2_q);
  assign hit_off = drfo_pkg::sat_add(run_q, {1'b0, into2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= drfo_pkg::ST_IDLE;
      mem_offset_q  <= '0;
      filt_en_q     <= 1'b0;
      filt_begin_q  <= '0;
      filt_length_q <= '0;
      block_count_q <= '0;
      n_q           <= '0;
      iss_q         <= '0;
      v0_q          <= 1'b0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          drfo_pkg::REG_MEMORY_OFFSET: mem_offset_q  <= cfg_data_i;
          drfo_pkg::REG_FILTER_ENABLE: filt_en_q     <= cfg_data_i[0];
          drfo_pkg::REG_FILTER_BEGIN:  filt_begin_q  <= cfg_data_i;
          drfo_pkg::REG_FILTER_LENGTH: filt_length_q <= cfg_data_i;
          drfo_pkg::REG_BLOCK_COUNT:   block_count_q <= cfg_data_i[drfo_pkg::CntW-1:0];
          default: ;
        endcase
      end
      if (state_q == drfo_pkg::ST_PREP) begin
        n_q <= (block_count_q > drfo_pkg::CntW'(drfo_pkg::MaxBlocks)) ?
               drfo_pkg::CntW'(drfo_pkg::MaxBlocks) : block_count_q;
      end
      if (state_q == drfo_pkg::ST_PREP) iss_q <= '0;
      else if (rd_en) iss_q <= iss_q + drfo_pkg::CntW'(1);
      v0_q <= rd_en && walk_stay;
      v1_q <= v0_q && walk_stay;
      v2_q <= v1_q && walk_stay;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[entry_index_i] <= '{base: entry_base_i,
                                    bend: {1'b0, entry_base_i} + {1'b0, entry_size_i}};
    end
    if (rd_en) rd_q <= table_mem[iss_q[drfo_pkg::IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      phys_q   <= phys_addr_i;
      maplen_q <= map_length_i;
    end
    if (state_q == drfo_pkg::ST_PREP) begin
      wend_q  <= {1'b0, filt_begin_q} + {1'b0, filt_length_q};
      pmend_q <= {1'b0, phys_q} + {1'b0, maplen_q};
    end
    l0_q     <= (iss_q + drfo_pkg::CntW'(1)) == n_q;
    start1_q <= start1_d;
    stop1_q  <= stop1_d;
    empty1_q <= empty1_d;
    l1_q     <= l0_q;
    size2_q  <= size2_d;
    hit2_q   <= hit2_d;
    into2_q  <= phys_q - start1_q;
    fsize2_q <= (pmend_q <= stop1_q) ? maplen_q : rem2_d[drfo_pkg::AddrW-1:0];
    l2_q     <= l1_q;
    if (state_q == drfo_pkg::ST_CHECK) begin
      run_q       <= {1'b0, mem_offset_q};
      res_found_q <= 1'b0;
      res_off_q   <= '0;
      res_size_q  <= '0;
    end else if (state_q == drfo_pkg::ST_WALK && v2_q) begin
      if (hit2_q) begin
        res_found_q <= 1'b1;
        res_off_q   <= hit_off;
        res_size_q  <= fsize2_q;
      end else begin
        run_q <= run_sum;
      end
    end
    if (out_load) begin
      out_found_q <= res_found_q;
      out_off_q   <= res_off_q;
      out_size_q  <= res_size_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign file_offset_o = out_off_q;
  assign file_size_o   = out_size_q;

  `DRFO_ASSERT(a_miss_zero, clk_i, rst_ni, (out_valid_o && !found_o) |-> (file_offset_o == '0 && file_size_o == '0), "miss result carries nonzero fields")
  `DRFO_ASSERT(a_pipe_in_walk, clk_i, rst_ni, (v0_q || v1_q || v2_q) |-> (state_q == drfo_pkg::ST_WALK), "walk pipeline busy outside walk")
  `DRFO_ASSERT_NEVER(a_issue_bound, clk_i, rst_ni, iss_q > n_q, "read issue passed entry count")

endmodule
